// ===== design/vcmp_pkg.sv =====
// Shared types and constants for the visual code module placer.
package vcmp_pkg;

	localparam int ROW_W       = 10;
	localparam int COL_W       = 10;
	localparam int FRAME_W     = 16;
	localparam int CRC_W       = 8;
	localparam int BYTE_W      = 8;
	localparam int CHUNK_BYTES = 42;
	localparam int POS_W       = 6;
	localparam int FIFO_DEPTH  = 2;
	localparam int PTR_W       = 1;
	localparam int FILL_W      = 2;
	localparam int BEAT_W      = 4;
	localparam int TDATA_W     = 40;

	localparam logic [ROW_W-1:0]   ROW_STEP      = 10'd7;
	localparam logic [ROW_W-1:0]   ROW_FIRST     = 10'd7;
	localparam logic [ROW_W-1:0]   ROW_TOP_END   = 10'd56;
	localparam logic [ROW_W-1:0]   ROW_BOT_START = 10'd560;
	localparam logic [ROW_W-1:0]   ROW_LAST      = 10'd616;
	localparam logic [COL_W-1:0]   COL_EDGE      = 10'd7;
	localparam logic [COL_W-1:0]   COL_INNER     = 10'd63;
	localparam logic [COL_W-1:0]   COL_SHORT_END = 10'd847;
	localparam logic [COL_W-1:0]   COL_LONG_END  = 10'd903;
	localparam logic [COL_W-1:0]   SLOT_ADVANCE  = 10'd56;
	localparam logic [FRAME_W-1:0] FRAME_FIRST   = 16'd1;
	localparam logic [CRC_W-1:0]   CRC_POLY      = 8'h07;
	localparam logic [CRC_W-1:0]   CRC_INIT      = 8'h00;

	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [FRAME_W-1:0] frame;
	} cursor_t;

	typedef struct packed {
		cursor_t           pos;
		logic [BYTE_W-1:0] data;
		logic              has_crc;
		cursor_t           slot;
		logic [CRC_W-1:0]  crc;
	} job_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

// ===== design/vcmp_front.sv =====
// Front part: accepts bytes, advances the cursor and CRC, and queues one job per byte.
module vcmp_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [vcmp_pkg::BYTE_W-1:0] s_tdata,
	input  vcmp_pkg::fifo_stat_t        stat,
	output logic                        push,
	output vcmp_pkg::job_t              job
);
	import vcmp_pkg::*;

	function automatic cursor_t wrap_check(input cursor_t c);
		cursor_t r;
		logic    at_long;
		r = c;
		at_long = (c.col == COL_LONG_END);
		if (c.col == COL_SHORT_END || at_long) begin
			if (c.row < ROW_TOP_END) begin
				r.col = COL_INNER;
				r.row = c.row + ROW_STEP;
			end else if (c.row == ROW_TOP_END) begin
				r.col = COL_EDGE;
				r.row = c.row + ROW_STEP;
			end else if (c.row < ROW_BOT_START) begin
				if (at_long) begin
					r.col = COL_EDGE;
					r.row = c.row + ROW_STEP;
				end
			end else if (c.row == ROW_BOT_START) begin
				if (at_long) begin
					r.col = COL_INNER;
					r.row = c.row + ROW_STEP;
				end
			end else if (c.row < ROW_LAST) begin
				r.col = COL_INNER;
				r.row = c.row + ROW_STEP;
			end else begin
				r.row   = ROW_FIRST;
				r.col   = COL_INNER;
				r.frame = c.frame + FRAME_W'(1);
			end
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] c;
		c = v;
		for (int i = 0; i < BYTE_W; i++) begin
			c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

	cursor_t          cur_q;
	cursor_t          slot_q;
	logic [CRC_W-1:0] crc_q;
	logic [POS_W-1:0] chunk_pos_q;

	cursor_t          pre_pos;
	cursor_t          byte_pos;
	cursor_t          post_pos;
	cursor_t          next_cur;
	cursor_t          slot_sel;
	logic [CRC_W-1:0] crc_next;
	logic             chunk_start;
	logic             chunk_end;

	always_comb begin
		chunk_start = (chunk_pos_q == '0);
		chunk_end   = (chunk_pos_q >= POS_W'(CHUNK_BYTES - 1));
		slot_sel    = chunk_start ? cur_q : slot_q;
		pre_pos     = cur_q;
		if (chunk_start) begin
			pre_pos.col = cur_q.col + SLOT_ADVANCE;
		end
		byte_pos     = wrap_check(pre_pos);
		post_pos     = byte_pos;
		post_pos.col = byte_pos.col + SLOT_ADVANCE;
		next_cur     = wrap_check(post_pos);
		crc_next     = crc8_byte(crc_q ^ s_tdata);
	end

	assign s_tready = !stat.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		job.pos     = byte_pos;
		job.data    = s_tdata;
		job.has_crc = chunk_end;
		job.slot    = slot_sel;
		job.crc     = crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.row   <= ROW_FIRST;
			cur_q.col   <= COL_INNER;
			cur_q.frame <= FRAME_FIRST;
			slot_q      <= '0;
			crc_q       <= CRC_INIT;
			chunk_pos_q <= '0;
		end else if (push) begin
			cur_q  <= next_cur;
			slot_q <= slot_sel;
			if (chunk_end) begin
				crc_q       <= CRC_INIT;
				chunk_pos_q <= '0;
			end else begin
				crc_q       <= crc_next;
				chunk_pos_q <= chunk_pos_q + POS_W'(1);
			end
		end
	end

endmodule

// ===== design/vcmp_queue.sv =====
// Short job queue between the front and back parts.
module vcmp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  vcmp_pkg::job_t       push_job,
	input  logic                 pop,
	output vcmp_pkg::job_t       head,
	output vcmp_pkg::fifo_stat_t stat
);
	import vcmp_pkg::*;

	job_t              mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == FILL_W'(FIFO_DEPTH));
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

// ===== design/vcmp_back.sv =====
// Back part: expands each queued job into module beats through an output register.
module vcmp_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vcmp_pkg::job_t               head,
	input  vcmp_pkg::fifo_stat_t         stat,
	output logic                         pop,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [vcmp_pkg::ROW_W-1:0]   pixel_row,
	output logic [vcmp_pkg::COL_W-1:0]   pixel_col,
	output logic                         dark,
	output logic [vcmp_pkg::FRAME_W-1:0] frame_index,
	output logic                         is_check,
	output logic                         last
);
	import vcmp_pkg::*;

	logic [BEAT_W-1:0] beat_q;
	logic              valid_q;
	logic [2:0]        k;
	logic [COL_W-1:0]  offs;
	logic              in_crc;
	logic              last_beat;
	logic              load;

	always_comb begin
		k         = beat_q[2:0];
		in_crc    = beat_q[3];
		offs      = {4'b0, k, 3'b0} - {7'b0, k};
		last_beat = (in_crc && k == 3'd7) || (!in_crc && k == 3'd7 && !head.has_crc);
		load      = !stat.empty && (!valid_q || m_tready);
		pop       = load && last_beat;
	end

	assign m_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				beat_q  <= last_beat ? '0 : beat_q + BEAT_W'(1);
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last <= last_beat;
			if (in_crc) begin
				pixel_row   <= head.slot.row;
				pixel_col   <= head.slot.col + offs;
				dark        <= head.crc[k];
				frame_index <= head.slot.frame;
				is_check    <= 1'b1;
			end else begin
				pixel_row   <= head.pos.row;
				pixel_col   <= head.pos.col + offs;
				dark        <= head.data[k];
				frame_index <= head.pos.frame;
				is_check    <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_q != '0) |-> !stat.empty)
		else $error("beat counter advanced with no job queued");
	a_crc_beats_need_crc: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q[3] |-> head.has_crc)
		else $error("check beats on a job without a chunk end");
	a_pop_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (valid_q && last && beat_q == '0))
		else $error("job retired without a final beat");
`endif

endmodule

// ===== design/visual_code_module_placer.sv =====
// Top level of the visual code module placer.
// An accepted byte reaches the master side via the job queue and output register.
// Each byte gives 8 beats, 16 on a chunk's last byte, one beat per cycle while
// m_tready is high; the back part's single output register sets this rate.
// The front accepts a new byte every cycle while the two-entry job queue has room.
// Reset is asynchronous: cursor at row 7, column 63, frame 1, CRC and chunk cleared.
module visual_code_module_placer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [vcmp_pkg::BYTE_W-1:0]   s_tdata,  // data_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [vcmp_pkg::TDATA_W-1:0]  m_tdata,  // pixel_row, pixel_col, dark, frame_index
	output logic                          m_tuser,  // is_check
	output logic                          m_tlast
);
	import vcmp_pkg::*;

	fifo_stat_t         stat;
	job_t               push_job;
	job_t               head;
	logic               push;
	logic               pop;
	logic [ROW_W-1:0]   pixel_row;
	logic [COL_W-1:0]   pixel_col;
	logic               dark;
	logic [FRAME_W-1:0] frame_index;

	vcmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.stat     (stat),
		.push     (push),
		.job      (push_job)
	);

	vcmp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	vcmp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.dark        (dark),
		.frame_index (frame_index),
		.is_check    (m_tuser),
		.last        (m_tlast)
	);

	assign m_tdata = {3'b0, frame_index, dark, pixel_col, pixel_row};

endmodule

// ===== test/visual_code_module_placer_tb.sv =====
// Testbench for the visual code module placer: predicts every module beat and checks the output stream.
module visual_code_module_placer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vcmp_pkg::*;

	localparam int MODULE_PX    = 7;
	localparam int STALL_CYCLES = 150;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 40;

	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic               dark;
		logic [FRAME_W-1:0] frame;
		logic               check;
		logic               last;
	} placed_module_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	logic [ROW_W-1:0]   cur_row;
	logic [COL_W-1:0]   cur_col;
	logic [FRAME_W-1:0] cur_frame;
	logic [CRC_W-1:0]   crc_acc;
	logic [POS_W-1:0]   chunk_fill;
	logic [ROW_W-1:0]   slot_row;
	logic [COL_W-1:0]   slot_col;
	logic [FRAME_W-1:0] slot_frame;

	placed_module_t expected_beats[$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_asks = 0;
	int stall_served = 0;
	int quiet_cycles = 0;
	int beat_errors = 0;
	int beats_checked = 0;
	int bytes_sent = 0;
	int chunks_closed = 0;
	int frames_entered = 0;

	visual_code_module_placer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void wrap_cursor();
		logic at_long;
		if (cur_col != COL_SHORT_END && cur_col != COL_LONG_END)
			return;
		at_long = (cur_col == COL_LONG_END);
		if (cur_row < ROW_TOP_END) begin
			cur_col = COL_INNER;
			cur_row = cur_row + ROW_STEP;
		end else if (cur_row == ROW_TOP_END) begin
			cur_col = COL_EDGE;
			cur_row = cur_row + ROW_STEP;
		end else if (cur_row < ROW_BOT_START) begin
			if (at_long) begin
				cur_col = COL_EDGE;
				cur_row = cur_row + ROW_STEP;
			end
		end else if (cur_row == ROW_BOT_START) begin
			if (at_long) begin
				cur_col = COL_INNER;
				cur_row = cur_row + ROW_STEP;
			end
		end else if (cur_row < ROW_LAST) begin
			cur_col = COL_INNER;
			cur_row = cur_row + ROW_STEP;
		end else begin
			cur_row = ROW_FIRST;
			cur_col = COL_INNER;
			cur_frame = cur_frame + 1'b1;
			frames_entered++;
		end
	endfunction

	function automatic void predict_modules(input logic [BYTE_W-1:0] value);
		placed_module_t pm;
		logic closes;
		closes = (int'(chunk_fill) + 1 >= CHUNK_BYTES);
		if (chunk_fill == 0) begin
			slot_row = cur_row;
			slot_col = cur_col;
			slot_frame = cur_frame;
			cur_col = cur_col + SLOT_ADVANCE;
		end
		wrap_cursor();
		for (int k = 0; k < 8; k++) begin
			pm.row = cur_row;
			pm.col = cur_col;
			pm.dark = value[k];
			pm.frame = cur_frame;
			pm.check = 1'b0;
			pm.last = (k == 7) && !closes;
			expected_beats.push_back(pm);
			cur_col = cur_col + COL_W'(MODULE_PX);
		end
		wrap_cursor();
		crc_acc = crc_acc ^ value;
		for (int k = 0; k < 8; k++)
			crc_acc = crc_acc[7] ? ((crc_acc << 1) ^ CRC_POLY) : (crc_acc << 1);
		if (closes) begin
			for (int k = 0; k < 8; k++) begin
				pm.row = slot_row;
				pm.col = slot_col + COL_W'(k * MODULE_PX);
				pm.dark = crc_acc[k];
				pm.frame = slot_frame;
				pm.check = 1'b1;
				pm.last = (k == 7);
				expected_beats.push_back(pm);
			end
			chunk_fill = '0;
			crc_acc = CRC_INIT;
			chunks_closed++;
		end else begin
			chunk_fill = chunk_fill + 1'b1;
		end
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_modules(value);
		bytes_sent++;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			beat_errors++;
		end
	endtask

	always @(posedge clk) begin : beat_check
		placed_module_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_beats.size() == 0) begin
				$display("%0t ns: beat with nothing expected, tdata %h", $time, m_tdata);
				beat_errors++;
			end else begin
				want = expected_beats.pop_front();
				check_field("pixel_row", want.row, m_tdata[9:0]);
				check_field("pixel_col", want.col, m_tdata[19:10]);
				check_field("dark", want.dark, m_tdata[20]);
				check_field("frame_index", want.frame, m_tdata[36:21]);
				check_field("is_check", want.check, m_tuser);
				check_field("last", want.last, m_tlast);
				beats_checked++;
			end
		end
	end

	always begin : sink_ready
		@(posedge clk);
		if (stall_asks != stall_served) begin
			m_tready <= 1'b0;
			for (int i = 0; i < STALL_CYCLES; i++)
				@(posedge clk);
			stall_served++;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("visual_code_module_placer test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_directed();
		logic [BYTE_W-1:0] patterns[10] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA,
			8'h55, 8'h0F, 8'hF0, 8'h07, 8'hE0};
		tx_idle_pct = 7;
		rx_idle_pct = 80;
		foreach (patterns[i])
			send_byte(patterns[i]);
	endtask

	task automatic test_random_bytes(input int count, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < count; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_asks++;
		for (int i = 0; i < 12; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic test_no_idle();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		for (int i = 0; i < 10; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	initial begin
		cur_row = ROW_FIRST;
		cur_col = COL_INNER;
		cur_frame = FRAME_FIRST;
		crc_acc = CRC_INIT;
		chunk_fill = '0;
		slot_row = '0;
		slot_col = '0;
		slot_frame = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_bytes(50, 7, 80);
		test_random_bytes(50, 80, 7);
		test_backpressure();
		test_no_idle();
		s_tvalid <= 1'b0;

		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0) begin
			$display("%0t ns: %0d beats never arrived", $time, expected_beats.size());
			beat_errors++;
		end

		$display("Sent %0d bytes and checked %0d module beats.", bytes_sent, beats_checked);
		$display("Closed %0d chunks with check modules and crossed %0d frame boundaries.",
			chunks_closed, frames_entered);
		if (beat_errors == 0)
			$display("visual_code_module_placer test passed");
		else
			$display("visual_code_module_placer test failed");
		$finish;
	end

endmodule
